// File: design/ptt_pkg.sv
// shared constants and sequencer state type for the page table translator
package ptt_pkg;

   localparam int PAGE_BITS_DEF   = 4;
   localparam int FRAME_BITS_DEF  = 3;
   localparam int OFFSET_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF  = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INCR,
      ST_SCAN,
      ST_EVICT,
      ST_OUT
   } state_type;

endpackage

// File: design/page_table_translate_lfu.sv
// page table translation with least-frequently-used replacement
// a hit passes through INCR then OUT, a fault through INCR, SCAN, EVICT then OUT
// a new item is accepted only in IDLE, once the previous result has been loaded into the response register
// a fault walks the access counters one per cycle through a single shared comparator
// reset (synchronous): pages below 2**FRAME_BITS resident in their own frames, others not,
// all dirty bits and access counts zero
module page_table_translate_lfu #(
   parameter int PAGE_BITS   = ptt_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS  = ptt_pkg::FRAME_BITS_DEF,
   parameter int OFFSET_BITS = ptt_pkg::OFFSET_BITS_DEF,
   parameter int COUNT_BITS  = ptt_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [PAGE_BITS+OFFSET_BITS-1:0]  req_virtual_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [FRAME_BITS+OFFSET_BITS-1:0] rsp_physical_address,
   output logic                              rsp_page_fault,
   output logic                              rsp_write_back,
   output logic [PAGE_BITS-1:0]              rsp_victim_page
);

   localparam int NUM_PAGES  = 1 << PAGE_BITS;
   localparam int NUM_FRAMES = 1 << FRAME_BITS;

   ptt_pkg::state_type state_ff, state_in;

   logic                  resident_ff  [NUM_PAGES];
   logic                  dirty_ff     [NUM_PAGES];
   logic [FRAME_BITS-1:0] frame_num_ff [NUM_PAGES];
   logic [COUNT_BITS-1:0] count_ff     [NUM_PAGES];

   logic [PAGE_BITS-1:0]   page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PAGE_BITS-1:0]   idx_ff;
   logic [PAGE_BITS-1:0]   best_ff;
   logic [COUNT_BITS-1:0]  best_count_ff;
   logic                   found_ff;
   logic [FRAME_BITS-1:0]  frame_ff;
   logic                   fault_ff;
   logic                   wb_ff;
   logic [PAGE_BITS-1:0]   victim_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS+OFFSET_BITS-1:0] rsp_phys_ff;
   logic                              rsp_fault_ff;
   logic                              rsp_wb_ff;
   logic [PAGE_BITS-1:0]              rsp_victim_ff;

   logic [PAGE_BITS-1:0]  cnt_addr;
   logic [COUNT_BITS-1:0] count_rd;
   logic [PAGE_BITS-1:0]  frame_addr;
   logic [FRAME_BITS-1:0] frame_rd;
   logic                  cand;
   logic                  req_accept;
   logic                  rsp_load;
   logic [NUM_PAGES-1:0]  resident_vec;

   // one counter port: requested page, scan position or victim
   always_comb begin
      unique case (state_ff)
         ptt_pkg::ST_SCAN:  cnt_addr = idx_ff;
         ptt_pkg::ST_EVICT: cnt_addr = best_ff;
         default:           cnt_addr = page_ff;
      endcase
   end

   assign count_rd   = count_ff[cnt_addr];
   assign frame_addr = (state_ff == ptt_pkg::ST_EVICT) ? best_ff : page_ff;
   assign frame_rd   = frame_num_ff[frame_addr];

   // shared comparator, strict less keeps the lowest index on ties
   assign cand = resident_ff[idx_ff] && (!found_ff || (count_rd < best_count_ff));

   assign req_ready  = (state_ff == ptt_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_load   = (state_ff == ptt_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ptt_pkg::ST_INCR;
            end
         end
         ptt_pkg::ST_INCR: begin
            state_in = resident_ff[page_ff] ? ptt_pkg::ST_OUT : ptt_pkg::ST_SCAN;
         end
         ptt_pkg::ST_SCAN: begin
            if (idx_ff == {PAGE_BITS{1'b1}}) begin
               state_in = ptt_pkg::ST_EVICT;
            end
         end
         ptt_pkg::ST_EVICT: begin
            state_in = ptt_pkg::ST_OUT;
         end
         ptt_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PAGES; i++) begin
            resident_ff[i]  <= (i < NUM_FRAMES);
            dirty_ff[i]     <= 1'b0;
            frame_num_ff[i] <= FRAME_BITS'(i);
            count_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ptt_pkg::ST_INCR: begin
               // saturating access count
               if (count_rd != {COUNT_BITS{1'b1}}) begin
                  count_ff[page_ff] <= count_rd + COUNT_BITS'(1);
               end
            end
            ptt_pkg::ST_EVICT: begin
               if (found_ff) begin
                  count_ff[best_ff]     <= COUNT_BITS'(1);
                  resident_ff[best_ff]  <= 1'b0;
                  dirty_ff[best_ff]     <= 1'b0;
                  frame_num_ff[page_ff] <= frame_rd;
               end
               resident_ff[page_ff] <= 1'b1;
               dirty_ff[page_ff]    <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         page_ff   <= req_virtual_address[PAGE_BITS+OFFSET_BITS-1:OFFSET_BITS];
         offset_ff <= req_virtual_address[OFFSET_BITS-1:0];
      end
      case (state_ff)
         ptt_pkg::ST_INCR: begin
            frame_ff  <= frame_rd;
            fault_ff  <= !resident_ff[page_ff];
            wb_ff     <= 1'b0;
            victim_ff <= '0;
            idx_ff    <= '0;
            found_ff  <= 1'b0;
         end
         ptt_pkg::ST_SCAN: begin
            if (cand) begin
               best_ff       <= idx_ff;
               best_count_ff <= count_rd;
               found_ff      <= 1'b1;
            end
            idx_ff <= idx_ff + PAGE_BITS'(1);
         end
         ptt_pkg::ST_EVICT: begin
            if (found_ff) begin
               frame_ff  <= frame_rd;
               wb_ff     <= dirty_ff[best_ff];
               victim_ff <= best_ff;
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_phys_ff   <= {frame_ff, offset_ff};
         rsp_fault_ff  <= fault_ff;
         rsp_wb_ff     <= wb_ff;
         rsp_victim_ff <= victim_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_write_back       = rsp_wb_ff;
   assign rsp_victim_page      = rsp_victim_ff;

   // resident flags packed for the occupancy check
   always_comb begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         resident_vec[i] = resident_ff[i];
      end
   end

   // requested page is resident once its fault is handled
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptt_pkg::ST_EVICT) |=> resident_ff[page_ff])
      else $error("faulting page not resident after eviction");

   // a hit reports no victim and no write-back
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_page_fault) |-> (!rsp_write_back && (rsp_victim_page == '0)))
      else $error("hit item carries eviction data");

   // never more resident pages than frames
   assert property (@(posedge clock) disable iff (reset)
      ($countones(resident_vec) <= NUM_FRAMES))
      else $error("resident pages exceed frame count");

   // a fault scan starts at the first page with no candidate yet
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ptt_pkg::ST_INCR) && !resident_ff[page_ff])
      |=> ((state_ff == ptt_pkg::ST_SCAN) && (idx_ff == '0) && !found_ff))
      else $error("victim scan started in a bad state");

endmodule
